[hdl/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the station pair tracker: table geometry,
// request and status codes, the screening result and the stored pair layout.
// ----------------------------------------------------------------------------
package spt_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int MAC_W       = 48;
	localparam int GROUP_BIT   = 40;

	localparam logic [11:0] MIN_FRAME_LEN = 12'd24;
	localparam logic [1:0]  KIND_MGMT     = 2'd0;
	localparam logic [1:0]  KIND_DATA     = 2'd1;
	localparam logic [1:0]  DIR_TO_DS     = 2'b01;
	localparam logic [1:0]  DIR_FROM_DS   = 2'b10;

	typedef enum logic [1:0] {
		OP_OBSERVE = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_READ    = 2'd2,
		OP_SPARE   = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_ADDED   = 4'd0,
		ST_DUP     = 4'd1,
		ST_FULL    = 4'd2,
		ST_KIND    = 4'd3,
		ST_SHORT   = 4'd4,
		ST_DIR     = 4'd5,
		ST_GROUP   = 4'd6,
		ST_CLEARED = 4'd7,
		ST_READ    = 4'd8,
		ST_BADIDX  = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		ACT_DONE = 2'd0,
		ACT_SCAN = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	typedef struct packed {
		status_t            status;
		action_t            action;
		logic [MAC_W-1:0]   bssid;
		logic [MAC_W-1:0]   station;
	} screen_t;

	typedef struct packed {
		logic [MAC_W-1:0]   bssid;
		logic [MAC_W-1:0]   station;
		logic signed [7:0]  signal;
	} pair_t;

endpackage

[hdl/spt_screen.sv]
// ----------------------------------------------------------------------------
// spt_screen
// Header checks for one request beat: frame kind, table full, length,
// direction and group bit, pair selection, the read index bound, and the action that follows.
// ----------------------------------------------------------------------------
module spt_screen import spt_pkg::*; (
	input  logic [1:0]       opcode,
	input  logic [1:0]       frame_kind,
	input  logic [11:0]      frame_length,
	input  logic [7:0]       frame_flags,
	input  logic [MAC_W-1:0] addr_one,
	input  logic [MAC_W-1:0] addr_two,
	input  logic [6:0]       read_index,
	input  logic [CNT_W-1:0] count,
	output screen_t          scr
);

	logic full;
	logic idx_ok;

	assign full   = count >= CNT_W'(TABLE_DEPTH);
	assign idx_ok = 32'(read_index) < 32'(count);

	always_comb begin
		scr.status  = ST_KIND;
		scr.action  = ACT_DONE;
		scr.bssid   = addr_one;
		scr.station = addr_two;
		case (opcode_t'(opcode))
			OP_OBSERVE: begin
				if (frame_kind != KIND_MGMT && frame_kind != KIND_DATA) begin
					scr.status = ST_KIND;
				end else if (full) begin
					scr.status = ST_FULL;
				end else if (frame_length < MIN_FRAME_LEN) begin
					scr.status = ST_SHORT;
				end else if (frame_flags[1:0] == DIR_TO_DS || frame_flags[1:0] == DIR_FROM_DS) begin
					if (frame_flags[1:0] == DIR_FROM_DS) begin
						scr.bssid   = addr_two;
						scr.station = addr_one;
					end
					if (scr.station[GROUP_BIT]) begin
						scr.status = ST_GROUP;
					end else begin
						scr.status = ST_ADDED;
						scr.action = ACT_SCAN;
					end
				end else begin
					scr.status = ST_DIR;
				end
			end
			OP_CLEAR: begin
				scr.status = ST_CLEARED;
			end
			OP_READ: begin
				if (idx_ok) begin
					scr.status = ST_READ;
					scr.action = ACT_READ;
				end else begin
					scr.status = ST_BADIDX;
				end
			end
			default: begin
				scr.status = ST_KIND;
			end
		endcase
	end

endmodule

[hdl/wlan_station_pair_tracker.sv]
// ----------------------------------------------------------------------------
// wlan_station_pair_tracker
// Deduplicating table of (BSSID, station) pairs seen in received frame
// headers, with clear and read-back requests.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. A frame that passes the header checks
// walks the stored pairs through the single-port table memory, one read per
// cycle, and is appended if no match is found. Frames that fail a check and
// clear requests go straight to the result, while reads first fetch the
// indexed pair from the table. The result sits in an output register, so
// the next request is taken while it waits. After reset the table is empty;
// stored entries are only ever read below the pair count.
module wlan_station_pair_tracker import spt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              opcode,
	input  logic [1:0]              frame_kind,
	input  logic [11:0]             frame_length,
	input  logic [7:0]              frame_flags,
	input  logic [MAC_W-1:0]        addr_one,
	input  logic [MAC_W-1:0]        addr_two,
	input  logic signed [7:0]       signal_level,
	input  logic [6:0]              read_index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [3:0]              status,
	output logic [7:0]              entry_count,
	output logic [MAC_W-1:0]        out_bssid,
	output logic [MAC_W-1:0]        out_station,
	output logic signed [7:0]       out_signal
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_READ = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic             cmp_v_s1;
	logic             out_valid_q;

	logic [MAC_W-1:0] key_bssid_q;
	logic [MAC_W-1:0] key_station_q;
	logic signed [7:0] key_signal_q;
	status_t          res_status_q;
	pair_t            res_pair_q;
	status_t          out_status_q;
	logic [7:0]       out_count_q;
	pair_t            out_pair_q;

	pair_t            mem_q [TABLE_DEPTH];
	pair_t            rd_pair_s1;

	screen_t          scr;
	logic             accept;
	logic             scan_more;
	logic             hit;
	logic             out_free;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	pair_t            wr_pair;

	spt_screen u_screen (
		.opcode       (opcode),
		.frame_kind   (frame_kind),
		.frame_length (frame_length),
		.frame_flags  (frame_flags),
		.addr_one     (addr_one),
		.addr_two     (addr_two),
		.read_index   (read_index),
		.count        (count_q),
		.scr          (scr)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign scan_more = scan_q < count_q;
	assign hit       = cmp_v_s1 && rd_pair_s1.bssid == key_bssid_q
	                   && rd_pair_s1.station == key_station_q;
	assign out_free  = !out_valid_q || out_ready;
	assign wr_pair   = '{bssid: key_bssid_q, station: key_station_q, signal: key_signal_q};

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_q[IDX_W-1:0];
		if (accept && scr.action == ACT_READ) begin
			rd_en   = 1'b1;
			rd_addr = IDX_W'(read_index);
		end
		if (state_q == S_SCAN && scan_more) begin
			rd_en = 1'b1;
		end
		wr_en = (state_q == S_SCAN) && !scan_more && !cmp_v_s1;
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[count_q[IDX_W-1:0]] <= wr_pair;
		end
		if (rd_en) begin
			rd_pair_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode_t'(opcode) == OP_CLEAR) begin
							count_q <= '0;
						end
						case (scr.action)
							ACT_SCAN: begin
								scan_q   <= '0;
								cmp_v_s1 <= 1'b0;
								state_q  <= S_SCAN;
							end
							ACT_READ: state_q <= S_READ;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					cmp_v_s1 <= scan_more;
					if (scan_more) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (hit) begin
						state_q <= S_DONE;
					end else if (wr_en) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_bssid_q   <= scr.bssid;
			key_station_q <= scr.station;
			key_signal_q  <= signal_level;
			res_status_q  <= scr.status;
			res_pair_q    <= '0;
		end
		if (state_q == S_SCAN) begin
			if (hit) begin
				res_status_q <= ST_DUP;
			end else if (wr_en) begin
				res_status_q <= ST_ADDED;
			end
		end
		if (state_q == S_READ) begin
			res_pair_q <= rd_pair_s1;
		end
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_count_q  <= 8'(count_q);
			out_pair_q   <= res_pair_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;
	assign out_bssid   = out_pair_q.bssid;
	assign out_station = out_pair_q.station;
	assign out_signal  = out_pair_q.signal;

endmodule
